### rtl/core/alec_pkg.sv
// Shared types, codes and constants for the audio layer effect chain.
// Holds the controller command struct, the step codes and the sine table entry function.
// No dependencies.
package alec_pkg;

   localparam int DEF_SAMPLE_BITS      = 24;
   localparam int DEF_PHASE_BITS       = 32;
   localparam int DEF_SINE_TABLE_DEPTH = 256;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_EFFECT_MODE    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MOD_DEPTH      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILTER_COEF    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COMP_THRESHOLD = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COMP_SLOPE     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COMP_MAKEUP    = 3'd6;

   localparam logic [1:0] MODE_TREMOLO = 2'd1;
   localparam logic [1:0] MODE_ROTARY  = 2'd2;

   localparam logic [15:0] TREM_SCALE  = 16'd38011;
   localparam logic [15:0] ROT_SCALE   = 16'd40632;
   localparam logic [15:0] DECAY_SCALE = 16'd53740;
   localparam logic [15:0] DEPTH_MIN   = 16'd65;

   localparam logic [16:0] UNITY_Q16     = 17'h10000;
   localparam logic [22:0] THRESH_RESET  = 23'h7FFFFF;
   localparam logic [16:0] SLOPE_RESET   = 17'h10000;
   localparam logic [16:0] MAKEUP_RESET  = 17'h10000;

   typedef enum logic [3:0] {
      OP_DQ, OP_GAIN, OP_ML, OP_MR, OP_FL, OP_FR,
      OP_CL1, OP_CR1, OP_CL2, OP_CR2, OP_PK
   } op_type;

   typedef struct packed {
      logic   load;
      logic   sine_rd;
      logic   mul;
      logic   wb;
      logic   out_load;
      op_type op;
   } cmd_type;

   // Q1.15 sine at table index idx, odd polynomial in Q30, rounded and clamped.
   function automatic logic signed [15:0] sine_q15(input int unsigned idx,
                                                   input int unsigned log_depth);
      logic [63:0] t, r, z, z2, a, s, v, neg;
      logic [1:0]  q;
      t  = 64'(idx) << (32 - log_depth);
      q  = t[31:30];
      r  = {34'd0, t[29:0]};
      z  = q[0] ? ((64'd1 << 30) - r) : r;
      z2 = (z * z) >> 30;
      a  = 64'd5026995 - ((z2 * 64'd172272) >> 30);
      a  = 64'd85569306 - ((z2 * a) >> 30);
      a  = 64'd693598669 - ((z2 * a) >> 30);
      a  = 64'd1686629713 - ((z2 * a) >> 30);
      s  = (z * a) >> 30;
      v  = (s + 64'd16384) >> 15;
      if (v > 64'd32767) v = 64'd32767;
      neg = 64'd0 - v;
      return q[1] ? neg[15:0] : v[15:0];
   endfunction

endpackage

### rtl/core/alec_req_if.sv
// Input channel of the effect chain: one stereo sample pair per beat.
// Depends on nothing.
interface alec_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;
   logic                          block_end;

   modport source (output valid, output left_in, output right_in, output block_end,
                   input ready);
   modport sink   (input valid, input left_in, input right_in, input block_end,
                   output ready);
endinterface

### rtl/core/alec_rsp_if.sv
// Result channel of the effect chain: processed pair and peak meter per beat.
// Depends on nothing.
interface alec_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;
   logic        [SAMPLE_BITS-2:0] peak_out;

   modport source (output valid, output left_out, output right_out, output peak_out,
                   input ready);
   modport sink   (input valid, input left_out, input right_out, input peak_out,
                   output ready);
endinterface

### rtl/core/audio_layer_effect_chain_top.sv
// Top level of the audio layer effect chain: tremolo or rotary modulation,
// one-pole lowpass, hard-knee compressor and peak meter per stereo beat.
// Uses alec_pkg, alec_req_if, alec_rsp_if, alec_ctrl and alec_datapath.
//
// req_chan takes one sample pair per beat; rsp_chan returns the processed pair
// and the peak meter. csr_we writes register csr_index with csr_wdata at once.
// A result is registered after its beat is accepted, through these steps: the
// sine ROM read, then eleven products on the one shared multiplier, each issued
// and then written back, then the load of the output register.
// A new beat is taken only after the previous result has been loaded.
// req_chan.ready is high only while no beat is in work; it stays high while a
// finished result waits, so the next beat starts during a stall.
// When rsp_chan stalls, the result holds in its output register and the
// following beat waits after its last step until that result is taken.
// Reset (synchronous) clears phase, filter, meter and handshake state and
// loads register defaults.
module audio_layer_effect_chain_top
   import alec_pkg::*;
#(
   parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS,
   parameter int PHASE_BITS       = DEF_PHASE_BITS,
   parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   alec_req_if.sink                  req_chan,
   alec_rsp_if.source                rsp_chan
);

   cmd_type cmd;

   alec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   alec_datapath #(
      .SAMPLE_BITS      (SAMPLE_BITS),
      .PHASE_BITS       (PHASE_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .left_in   (req_chan.left_in),
      .right_in  (req_chan.right_in),
      .block_end (req_chan.block_end),
      .left_out  (rsp_chan.left_out),
      .right_out (rsp_chan.right_out),
      .peak_out  (rsp_chan.peak_out)
   );

endmodule

### rtl/core/alec_ctrl.sv
// Controller of the effect chain: sequences the sine read and the shared
// multiplier steps, and owns the result valid flag. Uses alec_pkg.
module alec_ctrl
   import alec_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic [2:0] {ST_IDLE, ST_SINE, ST_MUL, ST_WB, ST_DONE} state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   function automatic op_type next_op(input op_type op);
      unique case (op)
         OP_DQ:   return OP_GAIN;
         OP_GAIN: return OP_ML;
         OP_ML:   return OP_MR;
         OP_MR:   return OP_FL;
         OP_FL:   return OP_FR;
         OP_FR:   return OP_CL1;
         OP_CL1:  return OP_CR1;
         OP_CR1:  return OP_CL2;
         OP_CL2:  return OP_CR2;
         OP_CR2:  return OP_PK;
         default: return OP_PK;
      endcase
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.op       = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SINE;
            end
         end
         ST_SINE: begin
            cmd.sine_rd = 1'b1;
            op_in       = OP_DQ;
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_WB;
         end
         ST_WB: begin
            cmd.wb = 1'b1;
            if (op_ff == OP_PK) begin
               state_in = ST_DONE;
            end else begin
               op_in    = next_op(op_ff);
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_DQ;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_accept_to_sine: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SINE))
      else $error("accepted beat did not start the sine read");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("stalled result dropped");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while stalled");
   a_done_after_pk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WB && op_ff == OP_PK) |=> (state_ff == ST_DONE))
      else $error("meter step not followed by result load");
`endif

endmodule

### rtl/core/alec_datapath.sv
// Datapath of the effect chain: configuration registers, sine ROM, one shared
// multiplier, filter and meter state, result register. Uses alec_pkg.
module alec_datapath
   import alec_pkg::*;
#(
   parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS,
   parameter int PHASE_BITS       = DEF_PHASE_BITS,
   parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  cmd_type                       cmd,
   input  logic signed [SAMPLE_BITS-1:0] left_in,
   input  logic signed [SAMPLE_BITS-1:0] right_in,
   input  logic                          block_end,
   output logic signed [SAMPLE_BITS-1:0] left_out,
   output logic signed [SAMPLE_BITS-1:0] right_out,
   output logic        [SAMPLE_BITS-2:0] peak_out
);

   localparam int SB        = SAMPLE_BITS;
   localparam int AW        = SB + 2;
   localparam int BW        = 18;
   localparam int PW        = AW + BW;
   localparam int CW        = ((SB > 23) ? SB : 23) + 2;
   localparam int LOG_DEPTH = $clog2(SINE_TABLE_DEPTH);

   localparam logic signed [PW-1:0] SMAX_W = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
   localparam logic signed [PW-1:0] SMIN_W = {{(PW-SB+1){1'b1}}, {(SB-1){1'b0}}};
   localparam logic signed [PW-1:0] HALF16 = PW'(32768);
   localparam logic signed [PW-1:0] HALF15 = PW'(16384);
   localparam logic signed [PW-1:0] UNITY  = PW'(65536);

   typedef logic signed [15:0] rom_type [SINE_TABLE_DEPTH];

   function automatic rom_type build_rom();
      rom_type rom;
      for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
         rom[i] = sine_q15(i, LOG_DEPTH);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   function automatic logic signed [SB-1:0] sat(input logic signed [PW-1:0] v);
      if (v > SMAX_W) return SMAX_W[SB-1:0];
      if (v < SMIN_W) return SMIN_W[SB-1:0];
      return v[SB-1:0];
   endfunction

   function automatic logic signed [PW-1:0] rnd16(input logic signed [PW-1:0] v);
      return (v + HALF16) >>> 16;
   endfunction

   function automatic logic [SB-1:0] mag(input logic signed [SB-1:0] v);
      return v[SB-1] ? (~v + 1'b1) : v;
   endfunction

   // configuration
   logic [1:0]  mode_ff;
   logic [15:0] depth_ff;
   logic [31:0] step_ff;
   logic [15:0] coef_ff;
   logic [22:0] thr_ff;
   logic [16:0] slope_ff;
   logic [16:0] makeup_ff;

   // state and working registers
   logic [PHASE_BITS-1:0]  phase_ff;
   logic signed [SB-1:0]   left_ff, right_ff, lp_l_ff, lp_r_ff;
   logic                   end_ff;
   logic [SB-2:0]          bmax_ff, peak_ff;
   logic signed [15:0]     sine_ff;
   logic [15:0]            dq_ff;
   logic signed [BW-1:0]   gain_l_ff, gain_r_ff;
   logic [SB-1:0]          mag_l_ff, mag_r_ff;
   logic signed [PW-1:0]   prod_ff;
   logic signed [SB-1:0]   lout_ff, rout_ff;
   logic [SB-2:0]          pout_ff;

   logic                   mod_on;
   logic [16:0]            slope_c;
   logic [SB-1:0]          m_l, m_r;
   logic                   over_l, over_r;
   logic signed [CW-1:0]   ex_l, ex_r;
   logic signed [SB:0]     dif_l, dif_r;
   logic signed [AW-1:0]   a_sel;
   logic signed [BW-1:0]   b_sel;
   logic signed [PW-1:0]   r16, p15, t16, fl_n, fr_n, thr_w, neg_v;
   logic [SB-1:0]          abs_l, abs_r;
   logic [SB-2:0]          cl_l, cl_r, mx, bm, dec;

   assign mod_on  = ((mode_ff == MODE_TREMOLO) || (mode_ff == MODE_ROTARY)) &&
                    (depth_ff > DEPTH_MIN);
   assign slope_c = (slope_ff > UNITY_Q16) ? UNITY_Q16 : slope_ff;
   assign m_l     = mag(left_ff);
   assign m_r     = mag(right_ff);
   assign ex_l    = CW'({1'b0, m_l}) - CW'({1'b0, thr_ff});
   assign ex_r    = CW'({1'b0, m_r}) - CW'({1'b0, thr_ff});
   assign over_l  = (CW'({1'b0, m_l}) > CW'({1'b0, thr_ff}));
   assign over_r  = (CW'({1'b0, m_r}) > CW'({1'b0, thr_ff}));
   assign dif_l   = {lp_l_ff[SB-1], lp_l_ff} - {left_ff[SB-1], left_ff};
   assign dif_r   = {lp_r_ff[SB-1], lp_r_ff} - {right_ff[SB-1], right_ff};

   always_comb begin
      a_sel = '0;
      b_sel = '0;
      unique case (cmd.op)
         OP_DQ: begin
            a_sel = {{(AW-16){1'b0}}, depth_ff};
            b_sel = {2'b00, (mode_ff == MODE_TREMOLO) ? TREM_SCALE : ROT_SCALE};
         end
         OP_GAIN: begin
            if (mode_ff == MODE_TREMOLO) begin
               a_sel = {{(AW-16){1'b0}}, dq_ff};
               b_sel = 18'sd32768 + {{2{sine_ff[15]}}, sine_ff};
            end else begin
               a_sel = {{(AW-16){sine_ff[15]}}, sine_ff};
               b_sel = {2'b00, dq_ff};
            end
         end
         OP_ML: begin
            a_sel = {{2{left_ff[SB-1]}}, left_ff};
            b_sel = gain_l_ff;
         end
         OP_MR: begin
            a_sel = {{2{right_ff[SB-1]}}, right_ff};
            b_sel = gain_r_ff;
         end
         OP_FL: begin
            a_sel = {dif_l[SB], dif_l};
            b_sel = {2'b00, coef_ff};
         end
         OP_FR: begin
            a_sel = {dif_r[SB], dif_r};
            b_sel = {2'b00, coef_ff};
         end
         OP_CL1: begin
            a_sel = ex_l[AW-1:0];
            b_sel = {1'b0, slope_c};
         end
         OP_CR1: begin
            a_sel = ex_r[AW-1:0];
            b_sel = {1'b0, slope_c};
         end
         OP_CL2: begin
            a_sel = {2'b00, mag_l_ff};
            b_sel = {1'b0, makeup_ff};
         end
         OP_CR2: begin
            a_sel = {2'b00, mag_r_ff};
            b_sel = {1'b0, makeup_ff};
         end
         OP_PK: begin
            a_sel = {3'b000, peak_ff};
            b_sel = {2'b00, DECAY_SCALE};
         end
         default: begin
            a_sel = '0;
            b_sel = '0;
         end
      endcase
   end

   always_comb begin
      r16   = rnd16(prod_ff);
      p15   = (prod_ff + HALF15) >>> 15;
      t16   = prod_ff >>> 16;
      fl_n  = {{(PW-SB){left_ff[SB-1]}}, left_ff} + r16;
      fr_n  = {{(PW-SB){right_ff[SB-1]}}, right_ff} + r16;
      thr_w = {{(PW-23){1'b0}}, thr_ff} + r16;
      neg_v = -r16;
      abs_l = mag(left_ff);
      abs_r = mag(right_ff);
      cl_l  = abs_l[SB-1] ? {(SB-1){1'b1}} : abs_l[SB-2:0];
      cl_r  = abs_r[SB-1] ? {(SB-1){1'b1}} : abs_r[SB-2:0];
      mx    = (cl_l > cl_r) ? cl_l : cl_r;
      bm    = (mx > bmax_ff) ? mx : bmax_ff;
      dec   = prod_ff[SB+14:16];
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= '0;
         depth_ff  <= '0;
         step_ff   <= '0;
         coef_ff   <= '0;
         thr_ff    <= THRESH_RESET;
         slope_ff  <= SLOPE_RESET;
         makeup_ff <= MAKEUP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EFFECT_MODE:    mode_ff   <= csr_wdata[1:0];
            CSR_MOD_DEPTH:      depth_ff  <= csr_wdata[15:0];
            CSR_PHASE_STEP:     step_ff   <= csr_wdata[31:0];
            CSR_FILTER_COEF:    coef_ff   <= csr_wdata[15:0];
            CSR_COMP_THRESHOLD: thr_ff    <= csr_wdata[22:0];
            CSR_COMP_SLOPE:     slope_ff  <= csr_wdata[16:0];
            CSR_COMP_MAKEUP:    makeup_ff <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         lp_l_ff  <= '0;
         lp_r_ff  <= '0;
         bmax_ff  <= '0;
         peak_ff  <= '0;
      end else begin
         if (cmd.sine_rd && mod_on) begin
            phase_ff <= phase_ff + step_ff[PHASE_BITS-1:0];
         end
         if (cmd.wb) begin
            unique case (cmd.op)
               OP_FL: lp_l_ff <= sat(fl_n);
               OP_FR: lp_r_ff <= sat(fr_n);
               OP_PK: begin
                  if (end_ff) begin
                     peak_ff <= (bm > dec) ? bm : dec;
                     bmax_ff <= '0;
                  end else begin
                     bmax_ff <= bm;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         end_ff   <= block_end;
      end
      if (cmd.sine_rd) begin
         sine_ff <= SINE_ROM[phase_ff[PHASE_BITS-1 -: LOG_DEPTH]];
      end
      if (cmd.mul) begin
         prod_ff <= a_sel * b_sel;
      end
      if (cmd.wb) begin
         unique case (cmd.op)
            OP_DQ: dq_ff <= prod_ff[31:16];
            OP_GAIN: begin
               if (!mod_on) begin
                  gain_l_ff <= UNITY[BW-1:0];
                  gain_r_ff <= UNITY[BW-1:0];
               end else if (mode_ff == MODE_TREMOLO) begin
                  gain_l_ff <= BW'(UNITY - t16);
                  gain_r_ff <= BW'(UNITY - t16);
               end else begin
                  gain_l_ff <= BW'(UNITY - p15);
                  gain_r_ff <= BW'(UNITY + p15);
               end
            end
            OP_ML:  left_ff  <= sat(r16);
            OP_MR:  right_ff <= sat(r16);
            OP_FL:  left_ff  <= sat(fl_n);
            OP_FR:  right_ff <= sat(fr_n);
            OP_CL1: mag_l_ff <= over_l ? thr_w[SB-1:0] : m_l;
            OP_CR1: mag_r_ff <= over_r ? thr_w[SB-1:0] : m_r;
            OP_CL2: left_ff  <= sat(left_ff[SB-1] ? neg_v : r16);
            OP_CR2: right_ff <= sat(right_ff[SB-1] ? neg_v : r16);
            default: ;
         endcase
      end
      if (cmd.out_load) begin
         lout_ff <= left_ff;
         rout_ff <= right_ff;
         pout_ff <= peak_ff;
      end
   end

   assign left_out  = lout_ff;
   assign right_out = rout_ff;
   assign peak_out  = pout_ff;

endmodule

### tb/sv/audio_layer_effect_chain_top_tb.sv
// Testbench for audio_layer_effect_chain_top: drives stereo beats under random idling,
// predicts modulation, lowpass, compressor and peak meter results, and checks each result.
// Depends on alec_pkg, alec_req_if, alec_rsp_if and the top level.
module audio_layer_effect_chain_top_tb;
   import alec_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;
   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   alec_req_if #(.SAMPLE_BITS(24)) req_chan ();
   alec_rsp_if #(.SAMPLE_BITS(24)) rsp_chan ();

   audio_layer_effect_chain_top uut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   always #5 clock = ~clock;

   typedef struct {
      logic signed [23:0] left;
      logic signed [23:0] right;
      logic [22:0]        peak;
   } pair_result_type;

   typedef struct {
      logic signed [23:0] left;
      logic signed [23:0] right;
      logic               last;
      logic               typed;
      logic signed [23:0] exp_left;
      logic signed [23:0] exp_right;
      logic [22:0]        exp_peak;
   } stim_row_type;

   pair_result_type pending_pairs[$];
   int errors = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   longint cycles = 0;
   bit calm = 1'b0;

   // shadow registers and state
   logic [1:0]  m_mode;
   logic [15:0] m_depth;
   logic [31:0] m_step;
   logic [15:0] m_coef;
   logic [22:0] m_thr;
   logic [16:0] m_slope;
   logic [16:0] m_makeup;
   logic [31:0] m_phase;
   longint m_lp_left, m_lp_right, m_blk_max, m_peak;

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clamp24(longint v);
      return v > 8388607 ? 8388607 : (v < -8388608 ? -8388608 : v);
   endfunction

   function automatic longint osc_sine(longint unsigned idx);
      longint unsigned t, q, r, z, z2, a, s, v;
      t = (idx << 32) / 256;
      q = (t >> 30) & 3;
      r = t & 64'h3FFFFFFF;
      z = q[0] ? (64'd1 << 30) - r : r;
      z2 = (z * z) >> 30;
      a = 64'd5026995 - ((z2 * 64'd172272) >> 30);
      a = 64'd85569306 - ((z2 * a) >> 30);
      a = 64'd693598669 - ((z2 * a) >> 30);
      a = 64'd1686629713 - ((z2 * a) >> 30);
      s = (z * a) >> 30;
      v = (s + 16384) >> 15;
      if (v > 32767) v = 32767;
      return q >= 2 ? -longint'(v) : longint'(v);
   endfunction

   function automatic longint smooth(longint x, ref longint y);
      longint n;
      n = clamp24(x + round_shift((y - x) * longint'(m_coef), 16));
      y = n;
      return n;
   endfunction

   function automatic longint squash(longint x);
      longint m, slope, thr;
      m = x < 0 ? -x : x;
      thr = longint'(m_thr);
      slope = m_slope > 17'h10000 ? 65536 : longint'(m_slope);
      if (m > thr) m = thr + round_shift((m - thr) * slope, 16);
      m = round_shift(m * longint'(m_makeup), 16);
      return clamp24(x < 0 ? -m : m);
   endfunction

   task automatic set_defaults();
      m_mode = MODE_NONE; m_depth = 0; m_step = 0; m_coef = 0;
      m_thr = THRESH_RESET; m_slope = SLOPE_RESET; m_makeup = MAKEUP_RESET;
      m_phase = 0; m_lp_left = 0; m_lp_right = 0; m_blk_max = 0; m_peak = 0;
   endtask

   function automatic pair_result_type process_pair(logic signed [23:0] li,
                                                    logic signed [23:0] ri, logic last);
      pair_result_type res;
      longint l, r, w, dq, g, p, al, ar, mx, d;
      l = li;
      r = ri;
      if ((m_mode == MODE_TREMOLO || m_mode == MODE_ROTARY) && m_depth > DEPTH_MIN) begin
         w = osc_sine((longint'(m_phase) * 256) >> 32);
         m_phase = m_phase + m_step;
         if (m_mode == MODE_TREMOLO) begin
            dq = (longint'(m_depth) * 38011) >>> 16;
            g = 65536 - ((dq * (32768 + w)) >>> 16);
            l = clamp24(round_shift(l * g, 16));
            r = clamp24(round_shift(r * g, 16));
         end else begin
            dq = (longint'(m_depth) * 40632) >>> 16;
            p = round_shift(w * dq, 15);
            l = clamp24(round_shift(l * (65536 - p), 16));
            r = clamp24(round_shift(r * (65536 + p), 16));
         end
      end
      l = squash(smooth(l, m_lp_left));
      r = squash(smooth(r, m_lp_right));
      al = l < 0 ? -l : l;
      ar = r < 0 ? -r : r;
      mx = al > ar ? al : ar;
      if (mx > 8388607) mx = 8388607;
      if (mx > m_blk_max) m_blk_max = mx;
      if (last) begin
         d = (m_peak * 53740) >>> 16;
         m_peak = m_blk_max > d ? m_blk_max : d;
         m_blk_max = 0;
      end
      res.left = l[23:0];
      res.right = r[23:0];
      res.peak = m_peak[22:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch on beat %0d: %s got %0d expected %0d", beats_checked, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      pair_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_pairs.size() == 0) begin
            report_mismatch("results pending", 0, 1);
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_chan.left_out !== want.left)
               report_mismatch("left_out", rsp_chan.left_out, want.left);
            if (rsp_chan.right_out !== want.right)
               report_mismatch("right_out", rsp_chan.right_out, want.right);
            if (rsp_chan.peak_out !== want.peak)
               report_mismatch("peak_out", rsp_chan.peak_out, want.peak);
         end
         beats_checked++;
      end
   end

   always @(negedge clock) rsp_chan.ready <= calm || ($urandom_range(99) >= 26);

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_EFFECT_MODE:    m_mode = val[1:0];
         CSR_MOD_DEPTH:      m_depth = val[15:0];
         CSR_PHASE_STEP:     m_step = val;
         CSR_FILTER_COEF:    m_coef = val[15:0];
         CSR_COMP_THRESHOLD: m_thr = val[22:0];
         CSR_COMP_SLOPE:     m_slope = val[16:0];
         CSR_COMP_MAKEUP:    m_makeup = val[16:0];
         default: ;
      endcase
   endtask

   // drive one beat; valid rises at a falling edge and holds until accepted
   task automatic send_beat(logic signed [23:0] l, logic signed [23:0] r, logic last,
                            logic typed, pair_result_type typed_res);
      pair_result_type res;
      @(negedge clock);
      while (!calm && $urandom_range(99) < 26) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.left_in = l;
      req_chan.right_in = r;
      req_chan.block_end = last;
      do @(posedge clock); while (!req_chan.ready);
      res = process_pair(l, r, last);
      pending_pairs = {pending_pairs, (typed ? typed_res : res)};
      beats_sent++;
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   task automatic drain();
      while (pending_pairs.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic signed [23:0] rand_sample();
      case ($urandom_range(7))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return 24'($urandom_range(4095) - 2048);
         default: return 24'($urandom);
      endcase
   endfunction

   stim_row_type rows[$];
   pair_result_type tr;

   task automatic add_row(int l, int r, bit last, bit typed, int el, int er, int ep);
      stim_row_type s;
      s.left = 24'(l); s.right = 24'(r); s.last = last; s.typed = typed;
      s.exp_left = 24'(el); s.exp_right = 24'(er); s.exp_peak = 23'(ep);
      rows = {rows, s};
   endtask

   task automatic random_phase(int count);
      repeat (count)
         send_beat(rand_sample(), rand_sample(), $urandom_range(7) == 0, 1'b0, tr);
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.left_in = '0;
      req_chan.right_in = '0;
      req_chan.block_end = 1'b0;
      set_defaults();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // after reset everything passes unchanged
      add_row(0, 0, 0, 1, 0, 0, 0);
      add_row(8388607, -8388608, 1, 1, 8388607, -8388608, 8388607);
      add_row(-8388607, 1, 0, 1, -8388607, 1, 8388607);
      add_row(0, 0, 1, 0, 0, 0, 0);
      add_row(0, 0, 1, 0, 0, 0, 0);
      add_row(123456, -654321, 1, 0, 0, 0, 0);
      add_row(-1, 1, 0, 0, 0, 0, 0);
      foreach (rows[i]) begin
         tr.left = rows[i].exp_left;
         tr.right = rows[i].exp_right;
         tr.peak = rows[i].exp_peak;
         send_beat(rows[i].left, rows[i].right, rows[i].last, rows[i].typed, tr);
      end
      drain();

      // tremolo, full depth, lowpass, hard compression, unused index ignored
      csr_write(CSR_EFFECT_MODE, 32'(MODE_TREMOLO));
      csr_write(CSR_MOD_DEPTH, 32'hFFFF);
      csr_write(CSR_PHASE_STEP, 32'h0100_0000);
      csr_write(CSR_FILTER_COEF, 32'h8000);
      csr_write(CSR_COMP_THRESHOLD, 32'd1000000);
      csr_write(CSR_COMP_SLOPE, 32'h4000);
      csr_write(CSR_COMP_MAKEUP, 32'h1FFFF);
      csr_write(CSR_UNUSED, 32'hFFFF_FFFF);
      send_beat(24'sh7FFFFF, 24'sh800000, 1, 0, tr);
      send_beat(24'sh800000, 24'sh7FFFFF, 0, 0, tr);
      random_phase(120);
      drain();

      // rotary, depth just above bypass, max step, slope clamp, zero threshold
      csr_write(CSR_EFFECT_MODE, 32'(MODE_ROTARY));
      csr_write(CSR_MOD_DEPTH, 32'd66);
      csr_write(CSR_PHASE_STEP, 32'hFFFF_FFFF);
      csr_write(CSR_FILTER_COEF, 32'hFFFF);
      csr_write(CSR_COMP_THRESHOLD, 32'd0);
      csr_write(CSR_COMP_SLOPE, 32'h1FFFF);
      csr_write(CSR_COMP_MAKEUP, 32'd0);
      send_beat(24'sh7FFFFF, 24'sh7FFFFF, 1, 0, tr);
      random_phase(80);
      drain();

      calm = 1'b1;
      csr_write(CSR_MOD_DEPTH, 32'hFFFF);
      csr_write(CSR_PHASE_STEP, 32'h0123_4567);
      csr_write(CSR_FILTER_COEF, 32'd0);
      csr_write(CSR_COMP_THRESHOLD, 32'h7FFFFF);
      csr_write(CSR_COMP_SLOPE, 32'd0);
      csr_write(CSR_COMP_MAKEUP, 32'h10000);
      random_phase(150);
      drain();
      calm = 1'b0;

      // depth at bypass limit, then unused mode
      csr_write(CSR_MOD_DEPTH, 32'd65);
      random_phase(40);
      drain();
      csr_write(CSR_MOD_DEPTH, 32'h9000);
      csr_write(CSR_EFFECT_MODE, 32'(MODE_SPARE));
      random_phase(40);
      drain();

      repeat (4) begin
         csr_write(CSR_EFFECT_MODE, $urandom_range(3));
         csr_write(CSR_MOD_DEPTH, $urandom_range(65535));
         csr_write(CSR_PHASE_STEP, $urandom);
         csr_write(CSR_FILTER_COEF, $urandom_range(65535));
         csr_write(CSR_COMP_THRESHOLD, $urandom_range(8388607));
         csr_write(CSR_COMP_SLOPE, $urandom_range(131071));
         csr_write(CSR_COMP_MAKEUP, $urandom_range(131071));
         random_phase(95);
         drain();
      end

      $display("sent %0d beats, checked %0d results", beats_sent, beats_checked);
      $display("covered bypass, tremolo, rotary, lowpass and compressor settings");
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

### sim.f
rtl/core/alec_pkg.sv
rtl/core/alec_req_if.sv
rtl/core/alec_rsp_if.sv
rtl/core/alec_ctrl.sv
rtl/core/alec_datapath.sv
rtl/core/audio_layer_effect_chain_top.sv
tb/sv/audio_layer_effect_chain_top_tb.sv
